FILE: rtl/scroll_velocity_multiplier_top_assert.svh
// Assertion macros for the scroll velocity multiplier checker.
// Depends on nothing; the including scope supplies i_clk and i_rst_n.
`ifndef SCROLL_VELOCITY_MULTIPLIER_TOP_ASSERT_SVH
`define SCROLL_VELOCITY_MULTIPLIER_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define SVM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define SVM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/svm_pkg.sv
// Shared types, register codes, reset values and constant tables.
// Used by svm_seq, the top level, the checker and the testbench.
package svm_pkg;

    typedef struct packed {
        logic [31:0] timestamp_us;
        logic        dir_positive;
        logic [9:0]  v120_amount;
    } t_in_word;

    typedef struct packed {
        logic [23:0] norm_interval_us;
        logic [16:0] instant_speed;
        logic [16:0] smoothed_speed;
        logic [15:0] multiplier;
        logic        restarted;
        logic        bad_amount;
    } t_out_word;

    typedef struct packed {
        logic [19:0] fast_interval_us;
        logic [19:0] slow_interval_us;
        logic [15:0] mult_lo;
        logic [15:0] mult_hi;
        logic [16:0] smoothing_gain;
        logic [15:0] curve_exponent;
    } t_cfg;

    typedef enum logic [2:0] {
        CFG_FAST     = 3'd0,
        CFG_SLOW     = 3'd1,
        CFG_MIN_MULT = 3'd2,
        CFG_MAX_MULT = 3'd3,
        CFG_GAIN     = 3'd4,
        CFG_EXPONENT = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAP,
        ST_NDIV,
        ST_NGET,
        ST_SPEED,
        ST_SDIV,
        ST_SGET,
        ST_AVG_OLD,
        ST_AVG_NEW,
        ST_LOG_INIT,
        ST_LOG,
        ST_POW,
        ST_EXP,
        ST_SHAPE,
        ST_MULT,
        ST_DONE
    } t_state;

    localparam logic [19:0] RST_FAST     = 20'd15000;
    localparam logic [19:0] RST_SLOW     = 20'd120000;
    localparam logic [15:0] RST_MIN_MULT = 16'd256;
    localparam logic [15:0] RST_MAX_MULT = 16'd1024;
    localparam logic [16:0] RST_GAIN     = 17'd32768;
    localparam logic [15:0] RST_EXPONENT = 16'd4096;

    localparam int FRAC_BITS = 28;

    typedef logic [FRAC_BITS-1:0][31:0] t_exp_tab;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_v;
        rem   = x;
        res   = 64'd0;
        bit_v = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // 2^(2^-k) in Q1.31, entry k-1 for k = 1..28
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab    tab;
        logic [63:0] c;
        c = 64'h1_0000_0000;
        for (int k = 0; k < FRAC_BITS; k++) begin
            c      = isqrt64(c << 31);
            tab[k] = c[31:0];
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

endpackage

FILE: rtl/svm_mul.sv
// Shared unsigned multiplier, 33 x 33 bits, combinational.
// Operands are muxed by the sequencer; the product lands in its registers.
module svm_mul (
    input  logic [32:0] i_a,
    input  logic [32:0] i_b,
    output logic [65:0] o_prod
);

    assign o_prod = {33'd0, i_a} * {33'd0, i_b};

endmodule

FILE: rtl/svm_div.sv
// Restoring divider, one quotient bit per step, quotient shifts into the low word.
// Driven by svm_seq; no package use.
module svm_div (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic        i_step,
    input  logic [19:0] i_rem,
    input  logic [23:0] i_lo,
    input  logic [19:0] i_den,
    output logic [23:0] o_quo
);

    logic [19:0] r_rem;
    logic [23:0] r_lo;
    logic [19:0] n_rem;
    logic [23:0] n_lo;
    logic [20:0] trial;
    logic        ge;

    always_comb begin
        trial = {r_rem, r_lo[23]};
        ge    = trial >= {1'b0, i_den};
        n_rem = r_rem;
        n_lo  = r_lo;
        if (i_load) begin
            n_rem = i_rem;
            n_lo  = i_lo;
        end else if (i_step) begin
            n_rem = ge ? 20'(trial - {1'b0, i_den}) : trial[19:0];
            n_lo  = {r_lo[22:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_lo  <= n_lo;
    end

    assign o_quo = r_lo;

endmodule

FILE: rtl/svm_seq.sv
// Sequencer and datapath: gap scaling, speed map, averaging, log/exp power, multiplier.
// Uses svm_pkg, svm_mul and svm_div.
module svm_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  svm_pkg::t_in_word  i_word,
    input  svm_pkg::t_cfg      i_cfg,
    output logic               o_busy,
    output logic               o_res_valid,
    input  logic               i_res_take,
    output svm_pkg::t_out_word o_res
);

    svm_pkg::t_state    r_state, n_state;
    logic [4:0]         r_cnt, n_cnt;
    logic [31:0]        r_last_time, n_last_time;
    logic               r_last_dir, n_last_dir;
    logic               r_seen, n_seen;
    logic [16:0]        r_avg, n_avg;
    logic [31:0]        r_gap, n_gap;
    logic [9:0]         r_amt, n_amt;
    logic [23:0]        r_norm, n_norm;
    logic [16:0]        r_inst, n_inst;
    logic [33:0]        r_acc, n_acc;
    logic [31:0]        r_m, n_m;
    logic [27:0]        r_frac, n_frac;
    logic [4:0]         r_e, n_e;
    logic [8:0]         r_n, n_n;
    logic [27:0]        r_g, n_g;
    logic               r_fzero, n_fzero;
    logic [32:0]        r_mant, n_mant;
    logic [16:0]        r_shaped, n_shaped;
    svm_pkg::t_out_word r_res, n_res;

    logic [32:0] mul_a, mul_b;
    logic [65:0] prod;
    logic        div_load, div_step;
    logic [19:0] div_rem, div_den;
    logic [23:0] div_lo, div_quo;

    logic        bad, restart, sat;
    logic        ge_slow, le_fast;
    logic [16:0] gain_sat, keep;
    logic [19:0] span;
    logic [4:0]  lead;
    logic [32:0] q;
    logic [36:0] y;
    logic [32:0] sq;
    logic [4:0]  exp_idx;
    logic [9:0]  sh;
    logic [40:0] rounded;
    logic [65:0] mant_rnd;
    logic [33:0] avg_sum, mult_sum;
    logic [31:0] m_init;

    svm_mul u_mul (.i_a(mul_a), .i_b(mul_b), .o_prod(prod));

    svm_div u_div (
        .i_clk (i_clk),
        .i_load(div_load),
        .i_step(div_step),
        .i_rem (div_rem),
        .i_lo  (div_lo),
        .i_den (div_den),
        .o_quo (div_quo)
    );

    always_comb begin
        bad      = i_word.v120_amount == 10'd0;
        restart  = !r_seen || (i_word.dir_positive != r_last_dir)
                   || (i_word.timestamp_us <= r_last_time);
        sat      = prod[38:24] >= {5'd0, r_amt};
        ge_slow  = r_norm >= {4'd0, i_cfg.slow_interval_us};
        le_fast  = r_norm <= {4'd0, i_cfg.fast_interval_us};
        gain_sat = (i_cfg.smoothing_gain > 17'd65536) ? 17'd65536 : i_cfg.smoothing_gain;
        keep     = 17'd65536 - gain_sat;
        span     = i_cfg.slow_interval_us - i_cfg.fast_interval_us;
        lead     = 5'd0;
        for (int i = 0; i < 17; i++) begin
            if (r_avg[i]) begin
                lead = 5'(i);
            end
        end
        m_init   = {15'd0, r_avg} << (5'd31 - lead);
        q        = {5'd16 - r_e, 28'd0} - {5'd0, r_frac};
        y        = prod[48:12];
        sq       = prod[63:31];
        exp_idx  = 5'd27 - r_cnt;
        sh       = {1'b0, r_n} + (r_fzero ? 10'd15 : 10'd16);
        rounded  = ({8'd0, r_mant} + (41'd1 << (sh[5:0] - 6'd1))) >> sh[5:0];
        mant_rnd = prod + (66'd1 << 30);
        avg_sum  = r_acc + {1'b0, prod[32:0]};
        mult_sum = {1'b0, prod[32:0]} + 34'd32768;
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = 33'd0;
        mul_b = 33'd0;
        case (r_state)
            svm_pkg::ST_GAP: begin
                mul_a = {1'b0, r_gap};
                mul_b = 33'd120;
            end
            svm_pkg::ST_AVG_OLD: begin
                mul_a = {16'd0, r_avg};
                mul_b = {16'd0, keep};
            end
            svm_pkg::ST_AVG_NEW: begin
                mul_a = {16'd0, r_inst};
                mul_b = {16'd0, gain_sat};
            end
            svm_pkg::ST_LOG: begin
                mul_a = {1'b0, r_m};
                mul_b = {1'b0, r_m};
            end
            svm_pkg::ST_POW: begin
                mul_a = q;
                mul_b = {17'd0, i_cfg.curve_exponent};
            end
            svm_pkg::ST_EXP: begin
                mul_a = r_mant;
                mul_b = {1'b0, svm_pkg::EXP_TAB[r_cnt]};
            end
            svm_pkg::ST_MULT: begin
                mul_a = {16'd0, r_shaped};
                mul_b = {17'd0, 16'(i_cfg.mult_hi - i_cfg.mult_lo)};
            end
            default: begin
                mul_a = 33'd0;
                mul_b = 33'd0;
            end
        endcase
    end

    // divider control
    always_comb begin
        div_load = 1'b0;
        div_step = 1'b0;
        div_rem  = {5'd0, prod[38:24]};
        div_lo   = prod[23:0];
        div_den  = {10'd0, r_amt};
        case (r_state)
            svm_pkg::ST_GAP: begin
                div_load = !sat;
            end
            svm_pkg::ST_NDIV: begin
                div_step = 1'b1;
            end
            svm_pkg::ST_SPEED: begin
                div_load = !ge_slow && !le_fast;
                div_rem  = 20'(i_cfg.slow_interval_us - r_norm[19:0]);
                div_lo   = 24'd0;
                div_den  = span;
            end
            svm_pkg::ST_SDIV: begin
                div_step = 1'b1;
                div_den  = span;
            end
            default: begin
                div_load = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            svm_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = (bad || restart) ? svm_pkg::ST_DONE : svm_pkg::ST_GAP;
                end
            end
            svm_pkg::ST_GAP:
                n_state = sat ? svm_pkg::ST_SPEED : svm_pkg::ST_NDIV;
            svm_pkg::ST_NDIV:
                n_state = (r_cnt == 5'd23) ? svm_pkg::ST_NGET : svm_pkg::ST_NDIV;
            svm_pkg::ST_NGET:
                n_state = svm_pkg::ST_SPEED;
            svm_pkg::ST_SPEED:
                n_state = (ge_slow || le_fast) ? svm_pkg::ST_AVG_OLD : svm_pkg::ST_SDIV;
            svm_pkg::ST_SDIV:
                n_state = (r_cnt == 5'd15) ? svm_pkg::ST_SGET : svm_pkg::ST_SDIV;
            svm_pkg::ST_SGET:
                n_state = svm_pkg::ST_AVG_OLD;
            svm_pkg::ST_AVG_OLD:
                n_state = svm_pkg::ST_AVG_NEW;
            svm_pkg::ST_AVG_NEW:
                n_state = svm_pkg::ST_LOG_INIT;
            svm_pkg::ST_LOG_INIT:
                n_state = (r_avg == 17'd0) ? svm_pkg::ST_MULT : svm_pkg::ST_LOG;
            svm_pkg::ST_LOG:
                n_state = (r_cnt == 5'd0) ? svm_pkg::ST_POW : svm_pkg::ST_LOG;
            svm_pkg::ST_POW:
                n_state = (y[27:0] == 28'd0) ? svm_pkg::ST_SHAPE : svm_pkg::ST_EXP;
            svm_pkg::ST_EXP:
                n_state = (r_cnt == 5'd27) ? svm_pkg::ST_SHAPE : svm_pkg::ST_EXP;
            svm_pkg::ST_SHAPE:
                n_state = svm_pkg::ST_MULT;
            svm_pkg::ST_MULT:
                n_state = svm_pkg::ST_DONE;
            svm_pkg::ST_DONE: begin
                if (i_res_take) begin
                    n_state = svm_pkg::ST_IDLE;
                end
            end
            default:
                n_state = svm_pkg::ST_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        n_cnt       = r_cnt;
        n_last_time = r_last_time;
        n_last_dir  = r_last_dir;
        n_seen      = r_seen;
        n_avg       = r_avg;
        n_gap       = r_gap;
        n_amt       = r_amt;
        n_norm      = r_norm;
        n_inst      = r_inst;
        n_acc       = r_acc;
        n_m         = r_m;
        n_frac      = r_frac;
        n_e         = r_e;
        n_n         = r_n;
        n_g         = r_g;
        n_fzero     = r_fzero;
        n_mant      = r_mant;
        n_shaped    = r_shaped;
        n_res       = r_res;
        case (r_state)
            svm_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_res.norm_interval_us = 24'd0;
                    n_res.instant_speed    = 17'd0;
                    n_res.smoothed_speed   = r_avg;
                    n_res.multiplier       = i_cfg.mult_lo;
                    n_res.restarted        = 1'b0;
                    n_res.bad_amount       = bad;
                    if (!bad) begin
                        n_last_time = i_word.timestamp_us;
                        n_last_dir  = i_word.dir_positive;
                        n_seen      = 1'b1;
                        n_gap       = i_word.timestamp_us - r_last_time;
                        n_amt       = i_word.v120_amount;
                        if (restart) begin
                            n_avg                = 17'd0;
                            n_res.smoothed_speed = 17'd0;
                            n_res.restarted      = 1'b1;
                        end
                    end
                end
            end
            svm_pkg::ST_GAP: begin
                n_cnt  = 5'd0;
                n_norm = 24'hFFFFFF;
            end
            svm_pkg::ST_NDIV: begin
                n_cnt = r_cnt + 5'd1;
            end
            svm_pkg::ST_NGET: begin
                n_norm = div_quo;
            end
            svm_pkg::ST_SPEED: begin
                n_cnt  = 5'd0;
                n_inst = ge_slow ? 17'd0 : 17'd65536;
            end
            svm_pkg::ST_SDIV: begin
                n_cnt = r_cnt + 5'd1;
            end
            svm_pkg::ST_SGET: begin
                n_inst = {1'b0, div_quo[15:0]};
            end
            svm_pkg::ST_AVG_OLD: begin
                n_acc = {1'b0, prod[32:0]} + 34'd32768;
            end
            svm_pkg::ST_AVG_NEW: begin
                n_avg = avg_sum[32:16];
            end
            svm_pkg::ST_LOG_INIT: begin
                n_shaped = 17'd0;
                n_e      = lead;
                n_m      = m_init;
                n_frac   = 28'd0;
                n_cnt    = 5'd27;
            end
            svm_pkg::ST_LOG: begin
                n_cnt = r_cnt - 5'd1;
                if (sq[32]) begin
                    n_frac[r_cnt] = 1'b1;
                    n_m           = sq[32:1];
                end else begin
                    n_m = sq[31:0];
                end
            end
            svm_pkg::ST_POW: begin
                n_n     = y[36:28];
                n_fzero = y[27:0] == 28'd0;
                n_g     = 28'd0 - y[27:0];
                n_mant  = 33'h0_8000_0000;
                n_cnt   = 5'd0;
            end
            svm_pkg::ST_EXP: begin
                n_cnt = r_cnt + 5'd1;
                if (r_g[exp_idx]) begin
                    n_mant = mant_rnd[63:31];
                end
            end
            svm_pkg::ST_SHAPE: begin
                n_shaped = (sh >= 10'd40) ? 17'd0 : rounded[16:0];
            end
            svm_pkg::ST_MULT: begin
                n_res.norm_interval_us = r_norm;
                n_res.instant_speed    = r_inst;
                n_res.smoothed_speed   = r_avg;
                n_res.restarted        = 1'b0;
                n_res.bad_amount       = 1'b0;
                if (i_cfg.mult_hi > i_cfg.mult_lo) begin
                    n_res.multiplier = i_cfg.mult_lo + mult_sum[31:16];
                end else begin
                    n_res.multiplier = i_cfg.mult_lo;
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= svm_pkg::ST_IDLE;
            r_last_time <= 32'd0;
            r_last_dir  <= 1'b0;
            r_seen      <= 1'b0;
            r_avg       <= 17'd0;
        end else begin
            r_state     <= n_state;
            r_last_time <= n_last_time;
            r_last_dir  <= n_last_dir;
            r_seen      <= n_seen;
            r_avg       <= n_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_gap    <= n_gap;
        r_amt    <= n_amt;
        r_norm   <= n_norm;
        r_inst   <= n_inst;
        r_acc    <= n_acc;
        r_m      <= n_m;
        r_frac   <= n_frac;
        r_e      <= n_e;
        r_n      <= n_n;
        r_g      <= n_g;
        r_fzero  <= n_fzero;
        r_mant   <= n_mant;
        r_shaped <= n_shaped;
        r_res    <= n_res;
    end

    assign o_busy      = r_state != svm_pkg::ST_IDLE;
    assign o_res_valid = r_state == svm_pkg::ST_DONE;
    assign o_res       = r_res;

endmodule

FILE: rtl/scroll_velocity_multiplier_top.sv
// Top level: config registers, input/output handshake and output register.
// Uses svm_pkg and svm_seq.
//
//  channel  direction  handshake               word
//  in       input      i_in_valid/o_in_stall   i_in_word (t_in_word)
//  out      output     o_out_valid/i_out_stall o_out_word (t_out_word)
//  cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A normal event runs through the 24-step and 16-step divisions
// and the two 28-step log and exp loops on the shared multiplier, each skipped when unneeded.
// A restart or zero-amount event goes straight from idle to the done state.
// Reset is synchronous; it clears the history and loads the default registers.
// o_in_stall is high while an event is in work; a stalled output word holds,
// and the next event is accepted while it waits.
module scroll_velocity_multiplier_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  svm_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output svm_pkg::t_out_word o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [19:0]        i_cfg_data
);

    svm_pkg::t_cfg      r_cfg;
    logic               r_out_valid;
    svm_pkg::t_out_word r_out_word;
    logic               busy, res_valid, res_take;
    svm_pkg::t_out_word res;

    assign o_cfg_ready = 1'b1;
    assign res_take    = res_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = busy;

    svm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in_valid && !busy),
        .i_word     (i_in_word),
        .i_cfg      (r_cfg),
        .o_busy     (busy),
        .o_res_valid(res_valid),
        .i_res_take (res_take),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_interval_us <= svm_pkg::RST_FAST;
            r_cfg.slow_interval_us <= svm_pkg::RST_SLOW;
            r_cfg.mult_lo          <= svm_pkg::RST_MIN_MULT;
            r_cfg.mult_hi          <= svm_pkg::RST_MAX_MULT;
            r_cfg.smoothing_gain   <= svm_pkg::RST_GAIN;
            r_cfg.curve_exponent   <= svm_pkg::RST_EXPONENT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                svm_pkg::CFG_FAST:     r_cfg.fast_interval_us <= i_cfg_data;
                svm_pkg::CFG_SLOW:     r_cfg.slow_interval_us <= i_cfg_data;
                svm_pkg::CFG_MIN_MULT: r_cfg.mult_lo          <= i_cfg_data[15:0];
                svm_pkg::CFG_MAX_MULT: r_cfg.mult_hi          <= i_cfg_data[15:0];
                svm_pkg::CFG_GAIN:     r_cfg.smoothing_gain   <= i_cfg_data[16:0];
                svm_pkg::CFG_EXPONENT: r_cfg.curve_exponent   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_word <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

FILE: rtl/svm_checker.sv
// Port-level checker for the scroll velocity multiplier, bound to the top level.
// Uses svm_pkg and scroll_velocity_multiplier_top_assert.svh.
`include "scroll_velocity_multiplier_top_assert.svh"

module svm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input svm_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input svm_pkg::t_out_word o_out_word,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic [2:0]         i_cfg_index,
    input logic [19:0]        i_cfg_data
);

    `SVM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word), "stalled output word changed")
    `SVM_ASSERT_SAME(a_after_reset, $past(!i_rst_n), !o_out_valid && !o_in_stall, "not idle after reset")
    `SVM_ASSERT_SAME(a_flags, o_out_valid, !(o_out_word.restarted && o_out_word.bad_amount), "restart and bad amount together")
    `SVM_ASSERT_SAME(a_restart_word, o_out_valid && (o_out_word.restarted || o_out_word.bad_amount), (o_out_word.norm_interval_us == 24'd0) && (o_out_word.instant_speed == 17'd0), "restart or bad word carries speed")
    `SVM_ASSERT_SAME(a_speed_range, o_out_valid, (o_out_word.instant_speed <= 17'd65536) && (o_out_word.smoothed_speed <= 17'd65536), "speed above one")

endmodule

bind scroll_velocity_multiplier_top svm_checker u_svm_checker (.*);

FILE: dv/scroll_velocity_multiplier_top_tb.sv
// Self-checking testbench for scroll_velocity_multiplier_top: a queue-fed driver,
// an output monitor and a bit-exact speed/multiplier predictor.
// Depends on rtl/svm_pkg.sv and the RTL of the block.
`timescale 1ns / 1ps

module scroll_velocity_multiplier_top_tb;

    localparam int MODE_FREE  = 0;
    localparam int MODE_SEND  = 1;
    localparam int MODE_STALL = 2;
    localparam int MODE_BOTH  = 3;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    svm_pkg::t_in_word  i_in_word;
    logic               o_out_valid;
    logic               i_out_stall;
    svm_pkg::t_out_word o_out_word;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [19:0]        i_cfg_data;

    scroll_velocity_multiplier_top u_top (.*);

    svm_pkg::t_in_word  pending_words[$];
    svm_pkg::t_out_word expected_words[$];
    svm_pkg::t_cfg      regs;
    logic [31:0]        prev_ts;
    logic               prev_dir;
    logic               have_prev;
    logic [16:0]        avg_speed;
    logic [31:0]        root_tab[1:28];
    int                 idle_pct;
    int                 stall_pct;
    int                 n_fail;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] rem, res, b;
        rem = x;
        res = 0;
        b = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // s in Q1.16, p in Q4.12, result s^p in Q1.16
    function automatic logic [16:0] speed_power(input logic [16:0] s, input logic [15:0] p);
        int          e, n, sh;
        logic [63:0] m, q, y, mant, f, g;
        logic [27:0] frac;
        if (s == 0) return 17'd0;
        e = 0;
        while (e < 16 && (s >> (e + 1)) != 0) e++;
        m = 64'(s) << (31 - e);
        frac = 0;
        for (int i = 27; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32)) begin
                frac[i] = 1'b1;
                m = m >> 1;
            end
        end
        q = (64'(16 - e) << 28) - 64'(frac);
        y = (q * 64'(p)) >> 12;
        n = int'(y >> 28);
        f = y & ((64'd1 << 28) - 1);
        if (f == 0) begin
            mant = 64'd1 << 31;
            sh = n + 15;
        end else begin
            g = (64'd1 << 28) - f;
            mant = 64'd1 << 31;
            for (int k = 1; k <= 28; k++)
                if (g[28 - k]) mant = (mant * 64'(root_tab[k]) + (64'd1 << 30)) >> 31;
            sh = n + 16;
        end
        if (sh >= 40) return 17'd0;
        return 17'((mant + (64'd1 << (sh - 1))) >> sh);
    endfunction

    function automatic svm_pkg::t_out_word predict_event(input svm_pkg::t_in_word w);
        svm_pkg::t_out_word r;
        logic [63:0]        norm, inst, g, span, avg, shaped, mult;
        r = '0;
        r.smoothed_speed = avg_speed;
        r.multiplier = regs.mult_lo;
        if (w.v120_amount == 0) begin
            r.bad_amount = 1'b1;
            return r;
        end
        if (!have_prev || w.dir_positive != prev_dir || w.timestamp_us <= prev_ts) begin
            avg_speed = 17'd0;
            r.smoothed_speed = 17'd0;
            r.restarted = 1'b1;
        end else begin
            norm = 64'(w.timestamp_us - prev_ts) * 120 / 64'(w.v120_amount);
            if (norm > 64'hFFFFFF) norm = 64'hFFFFFF;
            if (norm >= regs.slow_interval_us) inst = 0;
            else if (norm <= regs.fast_interval_us) inst = 65536;
            else begin
                span = 64'(regs.slow_interval_us) - 64'(regs.fast_interval_us);
                inst = ((64'(regs.slow_interval_us) - norm) << 16) / span;
            end
            g = (regs.smoothing_gain > 65536) ? 64'd65536 : 64'(regs.smoothing_gain);
            avg = (64'(avg_speed) * (65536 - g) + inst * g + 32768) >> 16;
            avg_speed = 17'(avg);
            shaped = 64'(speed_power(avg_speed, regs.curve_exponent));
            mult = 64'(regs.mult_lo);
            if (regs.mult_hi > regs.mult_lo)
                mult += (shaped * 64'(regs.mult_hi - regs.mult_lo) + 32768) >> 16;
            r.norm_interval_us = 24'(norm);
            r.instant_speed = 17'(inst);
            r.smoothed_speed = avg_speed;
            r.multiplier = 16'(mult);
        end
        prev_ts = w.timestamp_us;
        prev_dir = w.dir_positive;
        have_prev = 1'b1;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) expected_words.push_back(predict_event(i_in_word));
            if (!i_in_valid || !o_in_stall) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    i_in_word <= pending_words.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        svm_pkg::t_out_word x;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected output word %h", o_out_word);
                    n_fail++;
                end else begin
                    x = expected_words.pop_front();
                    if (o_out_word.norm_interval_us !== x.norm_interval_us) begin
                        $error("norm_interval_us exp %0d got %0d", x.norm_interval_us,
                               o_out_word.norm_interval_us);
                        n_fail++;
                    end
                    if (o_out_word.instant_speed !== x.instant_speed) begin
                        $error("instant_speed exp %0d got %0d", x.instant_speed,
                               o_out_word.instant_speed);
                        n_fail++;
                    end
                    if (o_out_word.smoothed_speed !== x.smoothed_speed) begin
                        $error("smoothed_speed exp %0d got %0d", x.smoothed_speed,
                               o_out_word.smoothed_speed);
                        n_fail++;
                    end
                    if (o_out_word.multiplier !== x.multiplier) begin
                        $error("multiplier exp %0d got %0d", x.multiplier,
                               o_out_word.multiplier);
                        n_fail++;
                    end
                    if (o_out_word.restarted !== x.restarted) begin
                        $error("restarted exp %0d got %0d", x.restarted, o_out_word.restarted);
                        n_fail++;
                    end
                    if (o_out_word.bad_amount !== x.bad_amount) begin
                        $error("bad_amount exp %0d got %0d", x.bad_amount,
                               o_out_word.bad_amount);
                        n_fail++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic write_reg(input svm_pkg::t_cfg_idx idx, input logic [19:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            svm_pkg::CFG_FAST:     regs.fast_interval_us = val;
            svm_pkg::CFG_SLOW:     regs.slow_interval_us = val;
            svm_pkg::CFG_MIN_MULT: regs.mult_lo = val[15:0];
            svm_pkg::CFG_MAX_MULT: regs.mult_hi = val[15:0];
            svm_pkg::CFG_GAIN:     regs.smoothing_gain = val[16:0];
            svm_pkg::CFG_EXPONENT: regs.curve_exponent = val[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_words.size() == 0 && !i_in_valid && expected_words.size() == 0);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic add_word(input logic [31:0] ts, input logic dir, input logic [9:0] amt);
        svm_pkg::t_in_word w;
        w.timestamp_us = ts;
        w.dir_positive = dir;
        w.v120_amount = amt;
        pending_words.push_back(w);
    endtask

    // mostly runs of same-direction events with gaps near the speed ramp
    task automatic add_random(input int count);
        logic [31:0] ts;
        logic        dir;
        logic [9:0]  amt;
        logic [63:0] target, gap;
        int          pick;
        ts = $urandom;
        dir = 1'($urandom_range(1));
        for (int i = 0; i < count; i++) begin
            amt = 10'($urandom_range(1, 1023));
            if ($urandom_range(3) == 0) amt = 10'($urandom_range(1, 240));
            pick = $urandom_range(99);
            if (pick < 4) begin
                amt = 0;
            end else if (pick < 8) begin
                dir = ~dir;
            end else if (pick < 11) begin
                ts = ts - 32'($urandom_range(0, 100000));
                add_word(ts, dir, amt);
                continue;
            end else if (pick < 14) begin
                ts = $urandom;
                add_word(ts, dir, amt);
                continue;
            end
            if (pick >= 14 && pick < 17) gap = 64'($urandom);
            else begin
                target = 64'($urandom_range(0,
                             regs.slow_interval_us + regs.slow_interval_us / 4 + 2));
                gap = target * amt / 120;
                if (gap == 0) gap = 1;
            end
            ts = ts + 32'(gap);
            add_word(ts, dir, amt);
        end
    endtask

    task automatic set_mode(input int mode);
        idle_pct = (mode == MODE_SEND || mode == MODE_BOTH) ? 67 : 0;
        stall_pct = (mode == MODE_STALL || mode == MODE_BOTH) ? 67 : 0;
        if (mode == MODE_BOTH) begin
            idle_pct = 33;
            stall_pct = 33;
        end
    endtask

    initial begin
        logic [63:0] c;
        c = 64'd1 << 32;
        for (int k = 1; k <= 28; k++) begin
            c = int_sqrt(c << 31);
            root_tab[k] = c[31:0];
        end
        regs = '{svm_pkg::RST_FAST, svm_pkg::RST_SLOW, svm_pkg::RST_MIN_MULT,
                 svm_pkg::RST_MAX_MULT, svm_pkg::RST_GAIN, svm_pkg::RST_EXPONENT};
        have_prev = 0;
        prev_ts = 0;
        prev_dir = 0;
        avg_speed = 0;
        n_fail = 0;
        idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = svm_pkg::CFG_FAST;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero amount before history, first event, extremes, restarts
        add_word(32'd1000, 1'b1, 10'd0);
        add_word(32'd1000, 1'b1, 10'd120);
        add_word(32'd1001, 1'b1, 10'd1023);
        add_word(32'd6001, 1'b1, 10'd120);
        add_word(32'd26001, 1'b1, 10'd120);
        add_word(32'd86001, 1'b1, 10'd120);
        add_word(32'd386001, 1'b1, 10'd120);
        add_word(32'd386001, 1'b1, 10'd120);
        add_word(32'd386000, 1'b1, 10'd120);
        add_word(32'd390000, 1'b0, 10'd120);
        add_word(32'd390001, 1'b0, 10'd1);
        add_word(32'd400000, 1'b0, 10'd0);
        add_word(32'd0, 1'b0, 10'd5);
        add_word(32'hFFFFFFFF, 1'b0, 10'd1);
        add_word(32'hFFFFFFFF, 1'b1, 10'd512);
        add_word(32'hFFFFFFFF, 1'b1, 10'd1);
        add_word(32'h00000000, 1'b1, 10'd1023);
        add_word(32'h00002000, 1'b1, 10'd1023);
        add_word(32'h00003000, 1'b1, 10'd1023);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            set_mode(ph % 4);
            if (ph == 7) begin
                idle_pct = 0;
                stall_pct = 0;
            end
            case (ph)
                1: begin
                    write_reg(svm_pkg::CFG_FAST, 20'd1);
                    write_reg(svm_pkg::CFG_SLOW, 20'hFFFFF);
                    write_reg(svm_pkg::CFG_MIN_MULT, 20'd1);
                    write_reg(svm_pkg::CFG_MAX_MULT, 20'hFFFFF);
                    write_reg(svm_pkg::CFG_GAIN, 20'd65536);
                    write_reg(svm_pkg::CFG_EXPONENT, 20'd65535);
                end
                2: begin
                    write_reg(svm_pkg::CFG_FAST, 20'hFFFFF);
                    write_reg(svm_pkg::CFG_SLOW, 20'd2);
                    write_reg(svm_pkg::CFG_MIN_MULT, 20'd65535);
                    write_reg(svm_pkg::CFG_MAX_MULT, 20'd1);
                    write_reg(svm_pkg::CFG_GAIN, 20'd1);
                    write_reg(svm_pkg::CFG_EXPONENT, 20'd1);
                end
                3: begin
                    write_reg(svm_pkg::CFG_FAST, 20'd2000);
                    write_reg(svm_pkg::CFG_SLOW, 20'd2000);
                    write_reg(svm_pkg::CFG_MIN_MULT, 20'd300);
                    write_reg(svm_pkg::CFG_MAX_MULT, 20'd300);
                    write_reg(svm_pkg::CFG_GAIN, 20'h1FFFF);
                    write_reg(svm_pkg::CFG_EXPONENT, 20'd0);
                end
                4: begin
                    write_reg(svm_pkg::CFG_FAST, 20'd5000);
                    write_reg(svm_pkg::CFG_SLOW, 20'd60000);
                    write_reg(svm_pkg::CFG_MIN_MULT, 20'd128);
                    write_reg(svm_pkg::CFG_MAX_MULT, 20'd4096);
                    write_reg(svm_pkg::CFG_GAIN, 20'd0);
                    write_reg(svm_pkg::CFG_EXPONENT, 20'd8192);
                end
                5: begin
                    write_reg(svm_pkg::CFG_GAIN, 20'd20000);
                    write_reg(svm_pkg::CFG_EXPONENT, 20'd2048);
                    write_reg(svm_pkg::CFG_MAX_MULT, 20'd65535);
                end
                6: begin
                    write_reg(svm_pkg::CFG_FAST, 20'($urandom_range(1, 40000)));
                    write_reg(svm_pkg::CFG_SLOW, 20'($urandom_range(40001, 200000)));
                    write_reg(svm_pkg::CFG_MIN_MULT, 20'($urandom_range(1, 1000)));
                    write_reg(svm_pkg::CFG_MAX_MULT, 20'($urandom_range(1000, 65535)));
                    write_reg(svm_pkg::CFG_GAIN, 20'($urandom_range(1, 65536)));
                    write_reg(svm_pkg::CFG_EXPONENT, 20'($urandom_range(1, 65535)));
                end
                7: begin
                    write_reg(svm_pkg::CFG_FAST, svm_pkg::RST_FAST);
                    write_reg(svm_pkg::CFG_SLOW, svm_pkg::RST_SLOW);
                    write_reg(svm_pkg::CFG_MIN_MULT, 20'(svm_pkg::RST_MIN_MULT));
                    write_reg(svm_pkg::CFG_MAX_MULT, 20'(svm_pkg::RST_MAX_MULT));
                    write_reg(svm_pkg::CFG_GAIN, 20'(svm_pkg::RST_GAIN));
                    write_reg(svm_pkg::CFG_EXPONENT, 20'(svm_pkg::RST_EXPONENT));
                end
                default: ;
            endcase
            add_random(66);
            drain();
        end

        if (n_fail == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: scroll_velocity_multiplier_top.f
+incdir+rtl
rtl/svm_pkg.sv
rtl/svm_mul.sv
rtl/svm_div.sv
rtl/svm_seq.sv
rtl/scroll_velocity_multiplier_top.sv
rtl/svm_checker.sv
dv/scroll_velocity_multiplier_top_tb.sv
